@@ rtl/core/i2cm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, opcodes and sequence tables for the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [3:0] {
    OP_START   = 4'd0,
    OP_RESTART = 4'd1,
    OP_STOP    = 4'd2,
    OP_SEND    = 4'd3,
    OP_ADDR_W  = 4'd4,
    OP_ADDR_R  = 4'd5,
    OP_READ    = 4'd6,
    OP_ACK     = 4'd7,
    OP_NAK     = 4'd8
  } opcode_e;

  localparam logic [6:0] ADDR_RESET  = 7'h68;
  localparam logic [4:0] SHIFT_STEPS = 5'd24;
  localparam logic [4:0] ACK_REL     = 5'd24;
  localparam logic [4:0] ACK_RISE    = 5'd25;
  localparam logic [4:0] ACK_SAMPLE  = 5'd26;
  localparam logic [4:0] READ_LAST   = 5'd15;
  localparam logic [4:0] START_LEN   = 5'd2;
  localparam logic [4:0] FIXED_LEN   = 5'd4;

  // Sequencer state carried between ticks
  typedef struct packed {
    logic [4:0] phase;
    opcode_e    cmd;
    logic [1:0] sub;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       ack;
    logic [7:0] rd_byte;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       nak_seen;
    logic [7:0] rx_byte;
  } result_t;

  // Fixed pin step: bit1 selects SDA (1) or SCL (0), bit0 is the level
  function automatic logic [1:0] seq_entry(opcode_e cmd, logic [1:0] idx);
    logic [1:0] e;
    e = 2'b00;
    case (cmd)
      OP_START:   e = (idx == 2'd0) ? 2'b10 : 2'b00;
      OP_RESTART: begin
        case (idx)
          2'd0:    e = 2'b11;
          2'd1:    e = 2'b01;
          2'd2:    e = 2'b10;
          default: e = 2'b00;
        endcase
      end
      OP_STOP: begin
        case (idx)
          2'd0:    e = 2'b00;
          2'd1:    e = 2'b10;
          2'd2:    e = 2'b01;
          default: e = 2'b11;
        endcase
      end
      OP_ACK: begin
        case (idx)
          2'd0:    e = 2'b10;
          2'd1:    e = 2'b01;
          2'd2:    e = 2'b00;
          default: e = 2'b11;
        endcase
      end
      OP_NAK: begin
        case (idx)
          2'd0:    e = 2'b11;
          2'd1:    e = 2'b01;
          2'd2:    e = 2'b00;
          default: e = 2'b11;
        endcase
      end
      default: e = 2'b00;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/i2cm_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels of the I2C bit-level master: tick, result, config.
// ----------------------------------------------------------------------------
interface i2cm_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [3:0] opcode;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, cmd_valid, opcode, tx_byte, sda_in, input ready);
  modport sink   (input valid, cmd_valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic       nak_seen;
  logic [7:0] rx_byte;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, nak_seen,
                  rx_byte, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, nak_seen,
                  rx_byte, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/i2c_bit_level_master.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Byte-command I2C master without clock stretching, one pin step per tick.
// A tick word's result is registered and appears in the cycle after it is accepted.
// Throughput: one tick word per cycle while res_o is ready; the result register frees in the
// same cycle it is taken, so the sequencer state loop sets the rate.
// Reset: asynchronous, idle with both pins released, address 0x68.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2cm_tick_if.sink  in_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_res_if.source res_o
);

  i2cm_pkg::state_t  st_q;
  i2cm_pkg::state_t  st_d;
  i2cm_pkg::result_t res_q;
  i2cm_pkg::result_t res_d;
  logic              out_valid_q;
  logic [6:0]        addr_q;
  logic              accept;

  assign in_i.ready  = !out_valid_q || res_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  i2cm_step u_step (
    .st_i        (st_q),
    .cmd_valid_i (in_i.cmd_valid),
    .opcode_i    (in_i.opcode),
    .tx_byte_i   (in_i.tx_byte),
    .sda_in_i    (in_i.sda_in),
    .dev_addr_i  (addr_q),
    .nxt_o       (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '{phase: 5'd0, cmd: i2cm_pkg::OP_START, sub: 2'd0, shift: 8'd0,
                        scl: 1'b1, sda: 1'b1, ack: 1'b0, rd_byte: 8'd0};
      out_valid_q  <= 1'b0;
      addr_q       <= i2cm_pkg::ADDR_RESET;
    end else begin
      if (accept) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        addr_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = res_q.scl_level;
  assign res_o.sda_level = res_q.sda_level;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.nak_seen  = res_q.nak_seen;
  assign res_o.rx_byte   = res_q.rx_byte;

  a_busy_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (st_q.phase != 5'd0) |=> res_q.busy_res)
    else $error("running sequence not reported busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_d.done_res |=> (st_q.phase == 5'd0))
    else $error("sequencer not idle after last step");

  a_read_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_d.busy_res && (st_d.cmd == i2cm_pkg::OP_READ) |=> res_q.sda_level)
    else $error("SDA driven during read");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase <= i2cm_pkg::ACK_SAMPLE + 5'd1)
    else $error("phase beyond last step");

endmodule
`default_nettype wire

@@ rtl/core/i2cm_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the command sequencer: next state and pin levels.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  var i2cm_pkg::state_t  st_i,
  input  wire logic             cmd_valid_i,
  input  wire logic [3:0]       opcode_i,
  input  wire logic [7:0]       tx_byte_i,
  input  wire logic             sda_in_i,
  input  wire logic [6:0]       dev_addr_i,
  output i2cm_pkg::state_t      nxt_o,
  output i2cm_pkg::result_t     res_o
);

  i2cm_pkg::state_t nxt;
  logic             busy;
  logic             done;
  logic             rel;
  logic [4:0]       step;
  logic [1:0]       e;

  always_comb begin
    nxt  = st_i;
    busy = 1'b0;
    done = 1'b0;
    rel  = 1'b0;
    step = st_i.phase;
    e    = 2'b00;

    if (st_i.phase != 5'd0) begin
      busy = 1'b1;
    end else if (cmd_valid_i && (opcode_i <= 4'(i2cm_pkg::OP_NAK))) begin
      busy    = 1'b1;
      step    = 5'd0;
      nxt.cmd = i2cm_pkg::opcode_e'(opcode_i);
      nxt.sub = 2'd0;
      case (i2cm_pkg::opcode_e'(opcode_i))
        i2cm_pkg::OP_SEND:   nxt.shift = tx_byte_i;
        i2cm_pkg::OP_ADDR_W: nxt.shift = {dev_addr_i, 1'b0};
        i2cm_pkg::OP_ADDR_R: nxt.shift = {dev_addr_i, 1'b1};
        i2cm_pkg::OP_READ:   nxt.shift = 8'd0;
        default:             nxt.shift = nxt.shift;
      endcase
    end

    if (busy) begin
      unique case (nxt.cmd) inside
        i2cm_pkg::OP_SEND, i2cm_pkg::OP_ADDR_W, i2cm_pkg::OP_ADDR_R: begin
          if (step < i2cm_pkg::SHIFT_STEPS) begin
            case (nxt.sub)
              2'd0:    nxt.sda = nxt.shift[7];
              2'd1:    nxt.scl = 1'b1;
              default: begin
                nxt.scl   = 1'b0;
                nxt.shift = {nxt.shift[6:0], 1'b0};
              end
            endcase
            nxt.sub = (nxt.sub == 2'd2) ? 2'd0 : nxt.sub + 2'd1;
          end else if (step == i2cm_pkg::ACK_REL) begin
            nxt.sda = 1'b1;
          end else if (step == i2cm_pkg::ACK_RISE) begin
            nxt.scl = 1'b1;
          end else if (step == i2cm_pkg::ACK_SAMPLE) begin
            nxt.ack = sda_in_i;
            rel     = 1'b1;
          end else begin
            nxt.scl = 1'b0;
            done    = 1'b1;
          end
        end
        i2cm_pkg::OP_READ: begin
          rel = 1'b1;
          if (!step[0]) begin
            nxt.shift = {nxt.shift[6:0], sda_in_i};
            nxt.scl   = 1'b1;
          end else begin
            nxt.scl = 1'b0;
            if (step >= i2cm_pkg::READ_LAST) begin
              nxt.rd_byte = nxt.shift;
              done        = 1'b1;
            end
          end
        end
        default: begin
          e = i2cm_pkg::seq_entry(nxt.cmd, step[1:0]);
          if (e[1]) begin
            nxt.sda = e[0];
          end else begin
            nxt.scl = e[0];
          end
          done = ((step + 5'd1) >= ((nxt.cmd == i2cm_pkg::OP_START) ?
                  i2cm_pkg::START_LEN : i2cm_pkg::FIXED_LEN));
        end
      endcase
      nxt.phase = done ? 5'd0 : step + 5'd1;
    end
  end

  assign nxt_o = nxt;

  always_comb begin
    res_o.scl_level = nxt.scl;
    res_o.sda_level = rel | nxt.sda;
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.nak_seen  = nxt.ack;
    res_o.rx_byte   = nxt.rd_byte;
  end

endmodule
`default_nettype wire

@@ tb/sv/i2cm_pin_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cm_pin_monitor
// Watches the tick, config and result channels of the I2C bit-level master.
// Keeps its own copy of the sequencer, predicts the pin levels and status of
// every accepted tick word and compares them with the result words in order.
// ----------------------------------------------------------------------------
module i2cm_pin_monitor
  import i2cm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  i2cm_tick_if tick_i,
  i2cm_cfg_if  cfg_i,
  i2cm_res_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef enum logic [1:0] {
    SCL_LOW  = 2'b00,
    SCL_HIGH = 2'b01,
    SDA_LOW  = 2'b10,
    SDA_HIGH = 2'b11
  } pin_step_e;

  logic [6:0] dev_addr;
  logic [4:0] seq_phase;
  logic [3:0] cur_cmd;
  logic [7:0] shreg;
  logic       scl_q;
  logic       sda_q;
  logic       ack_q;
  logic [7:0] rx_q;
  int         mismatches;
  result_t    levels_q[$];
  result_t    want;
  result_t    pred;

  task automatic predict_levels(input logic cv, input logic [3:0] op, input logic [7:0] tx,
                                input logic sda_in, output result_t r);
    logic      busy;
    logic      done;
    logic      released;
    logic [4:0] step;
    logic [4:0] seq_len;
    pin_step_e pin;
    busy     = 1'b0;
    done     = 1'b0;
    released = 1'b0;
    step     = '0;
    seq_len  = '0;
    pin      = SCL_LOW;
    if (seq_phase != 5'd0) begin
      busy = 1'b1;
      step = seq_phase;
    end else if (cv && op <= OP_NAK) begin
      busy    = 1'b1;
      cur_cmd = op;
      case (op)
        OP_SEND:   shreg = tx;
        OP_ADDR_W: shreg = {dev_addr, 1'b0};
        OP_ADDR_R: shreg = {dev_addr, 1'b1};
        OP_READ:   shreg = 8'h00;
        default:   ;
      endcase
    end
    if (busy) begin
      if (cur_cmd == OP_SEND || cur_cmd == OP_ADDR_W || cur_cmd == OP_ADDR_R) begin
        if (step < SHIFT_STEPS) begin
          case (step % 5'd3)
            5'd0:    sda_q = shreg[7];
            5'd1:    scl_q = 1'b1;
            default: begin
              scl_q = 1'b0;
              shreg = {shreg[6:0], 1'b0};
            end
          endcase
        end else if (step == ACK_REL) begin
          sda_q = 1'b1;
        end else if (step == ACK_RISE) begin
          scl_q = 1'b1;
        end else if (step == ACK_SAMPLE) begin
          ack_q    = sda_in;
          released = 1'b1;
        end else begin
          scl_q = 1'b0;
          done  = 1'b1;
        end
      end else if (cur_cmd == OP_READ) begin
        released = 1'b1;
        if (!step[0]) begin
          shreg = {shreg[6:0], sda_in};
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
          if (step >= READ_LAST) begin
            rx_q = shreg;
            done = 1'b1;
          end
        end
      end else begin
        seq_len = (cur_cmd == OP_START) ? START_LEN : FIXED_LEN;
        case (cur_cmd)
          OP_START: pin = (step[1:0] == 2'd0) ? SDA_LOW : SCL_LOW;
          OP_RESTART: begin
            case (step[1:0])
              2'd0:    pin = SDA_HIGH;
              2'd1:    pin = SCL_HIGH;
              2'd2:    pin = SDA_LOW;
              default: pin = SCL_LOW;
            endcase
          end
          OP_STOP: begin
            case (step[1:0])
              2'd0:    pin = SCL_LOW;
              2'd1:    pin = SDA_LOW;
              2'd2:    pin = SCL_HIGH;
              default: pin = SDA_HIGH;
            endcase
          end
          OP_ACK: begin
            case (step[1:0])
              2'd0:    pin = SDA_LOW;
              2'd1:    pin = SCL_HIGH;
              2'd2:    pin = SCL_LOW;
              default: pin = SDA_HIGH;
            endcase
          end
          default: begin
            case (step[1:0])
              2'd0:    pin = SDA_HIGH;
              2'd1:    pin = SCL_HIGH;
              2'd2:    pin = SCL_LOW;
              default: pin = SDA_HIGH;
            endcase
          end
        endcase
        if (pin[1]) begin
          sda_q = pin[0];
        end else begin
          scl_q = pin[0];
        end
        done = (step + 5'd1 >= seq_len);
      end
      seq_phase = done ? 5'd0 : step + 5'd1;
    end
    r.scl_level = scl_q;
    r.sda_level = released ? 1'b1 : sda_q;
    r.busy_res  = busy;
    r.done_res  = done;
    r.nak_seen  = ack_q;
    r.rx_byte   = rx_q;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr   = ADDR_RESET;
      seq_phase  = '0;
      cur_cmd    = '0;
      shreg      = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      ack_q      = 1'b0;
      rx_q       = '0;
      mismatches = 0;
      levels_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (levels_q.size() == 0) begin
          $error("result word with no expectation: scl %0b sda %0b busy %0b done %0b",
                 res_i.scl_level, res_i.sda_level, res_i.busy_res, res_i.done_res);
          mismatches++;
        end else begin
          want = levels_q.pop_front();
          check_field("scl_level", want.scl_level, res_i.scl_level);
          check_field("sda_level", want.sda_level, res_i.sda_level);
          check_field("busy_res", want.busy_res, res_i.busy_res);
          check_field("done_res", want.done_res, res_i.done_res);
          check_field("nak_seen", want.nak_seen, res_i.nak_seen);
          check_field("rx_byte", want.rx_byte, res_i.rx_byte);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        dev_addr = cfg_i.data;
      end
      if (tick_i.valid && tick_i.ready) begin
        predict_levels(tick_i.cmd_valid, tick_i.opcode, tick_i.tx_byte, tick_i.sda_in, pred);
        levels_q.push_back(pred);
      end
      fail_count_o <= mismatches;
      pending_o    <= levels_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick words into the I2C bit-level master: a directed pass over all
// commands and edge cases, then random well-formed bus transactions mixed
// with stray and invalid commands, under several device addresses and
// idling patterns. The pin monitor checks every result word.
// ----------------------------------------------------------------------------
module testbench;
  import i2cm_pkg::*;

  localparam int WORDS_PER_SEGMENT = 200;
  localparam int SEGMENTS          = 6;
  localparam int LONG_HOLD         = 200;
  localparam int QUIET_LIMIT       = 3000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int PAD_TICKS         = 30;

  typedef enum int {SDA_ZERO, SDA_ONE, SDA_RANDOM} sda_mode_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_words;
  int   words_sent;
  int   sender_idle_pct;
  int   recv_idle_pct;
  int   noise_pct;
  int   hold_reqs;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;

  i2cm_tick_if tick_if ();
  i2cm_res_if  res_if ();
  i2cm_cfg_if  cfg_if ();

  i2c_bit_level_master i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  i2cm_pin_monitor i_pin_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_if),
    .cfg_i        (cfg_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(input logic cv, input logic [3:0] op, input logic [7:0] tx,
                           input logic sda);
    while ($urandom_range(99) < sender_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid     <= 1'b1;
    tick_if.cmd_valid <= cv;
    tick_if.opcode    <= op;
    tick_if.tx_byte   <= tx;
    tick_if.sda_in    <= sda;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_word(1'b0, 4'($urandom_range(15)), 8'($urandom), 1'($urandom_range(1)));
  endtask

  // Issue a command, then fill the rest of its sequence with ticks
  task automatic run_command(input logic [3:0] op, input logic [7:0] tx, input sda_mode_e mode);
    int   n;
    int   i;
    logic sda;
    if (op == OP_START) begin
      n = 2;
    end else if (op == OP_SEND || op == OP_ADDR_W || op == OP_ADDR_R) begin
      n = 28;
    end else if (op == OP_READ) begin
      n = 16;
    end else if (op <= OP_NAK) begin
      n = 4;
    end else begin
      n = 1;
    end
    for (i = 0; i < n; i++) begin
      sda = (mode == SDA_ZERO) ? 1'b0 : (mode == SDA_ONE) ? 1'b1 : 1'($urandom_range(1));
      if (i == 0) begin
        send_word(1'b1, op, tx, sda);
      end else if ($urandom_range(99) < noise_pct) begin
        send_word(1'b1, 4'($urandom_range(15)), 8'($urandom), sda);
      end else begin
        send_word(1'b0, 4'($urandom_range(15)), 8'($urandom), sda);
      end
    end
  endtask

  // Return the sequencer to idle, then hold until every result is back
  task automatic drain_results();
    idle_ticks(PAD_TICKS);
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    res_if.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int seg_end;
    int pick;
    int legs;
    int leg;
    int nbytes;
    int b;
    rst_ni            = 1'b0;
    quiet_cycles      = 0;
    words_sent        = 0;
    hold_reqs         = 0;
    noise_pct         = 0;
    sender_idle_pct   = 30;
    recv_idle_pct     = 61;
    tick_if.valid     <= 1'b0;
    tick_if.cmd_valid <= 1'b0;
    tick_if.opcode    <= OP_START;
    tick_if.tx_byte   <= 8'h00;
    tick_if.sda_in    <= 1'b1;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= 7'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass at the reset address
    idle_ticks(2);
    run_command(4'd15, 8'hFF, SDA_ONE);
    run_command(4'd9, 8'h00, SDA_ZERO);
    run_command(OP_ACK, 8'h00, SDA_RANDOM);
    run_command(OP_START, 8'h00, SDA_RANDOM);
    noise_pct = 50;
    run_command(OP_ADDR_W, 8'h00, SDA_ZERO);
    noise_pct = 0;
    run_command(OP_SEND, 8'hFF, SDA_ONE);
    run_command(OP_SEND, 8'h00, SDA_ZERO);
    run_command(OP_SEND, 8'hA5, SDA_RANDOM);
    run_command(OP_RESTART, 8'h00, SDA_RANDOM);
    run_command(OP_ADDR_R, 8'h00, SDA_ZERO);
    run_command(OP_READ, 8'h00, SDA_ONE);
    run_command(OP_ACK, 8'h00, SDA_RANDOM);
    run_command(OP_READ, 8'h00, SDA_ZERO);
    run_command(OP_ACK, 8'h00, SDA_RANDOM);
    run_command(OP_READ, 8'h00, SDA_RANDOM);
    run_command(OP_NAK, 8'h00, SDA_RANDOM);
    run_command(OP_STOP, 8'h00, SDA_RANDOM);
    send_word(1'b0, OP_START, 8'h3C, 1'b0);
    run_command(OP_NAK, 8'h00, SDA_RANDOM);

    noise_pct = 10;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= (seg == 0) ? 7'h7F : (seg == 1) ? 7'h00 : 7'($urandom_range(127));
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      cfg_if.valid <= 1'b0;
      if (seg < 2) begin
        sender_idle_pct = 30;
        recv_idle_pct   = 61;
      end else if (seg < 4) begin
        sender_idle_pct = 61;
        recv_idle_pct   = 30;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      if (seg == 1 || seg == 4) begin
        hold_reqs++;
      end
      seg_end = words_sent + WORDS_PER_SEGMENT;
      while (words_sent < seg_end) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          run_command(OP_START, 8'($urandom), SDA_RANDOM);
          legs = $urandom_range(1, 2);
          for (leg = 0; leg < legs; leg++) begin
            if (leg > 0) begin
              run_command(OP_RESTART, 8'($urandom), SDA_RANDOM);
            end
            if ($urandom_range(1) == 1) begin
              run_command(OP_ADDR_W, 8'($urandom), SDA_RANDOM);
              repeat ($urandom_range(1, 2)) run_command(OP_SEND, 8'($urandom), SDA_RANDOM);
            end else begin
              run_command(OP_ADDR_R, 8'($urandom), SDA_RANDOM);
              nbytes = $urandom_range(1, 2);
              for (b = 0; b < nbytes; b++) begin
                run_command(OP_READ, 8'($urandom), SDA_RANDOM);
                run_command((b == nbytes - 1) ? OP_NAK : OP_ACK, 8'($urandom), SDA_RANDOM);
              end
            end
          end
          run_command(OP_STOP, 8'($urandom), SDA_RANDOM);
        end else if (pick < 92) begin
          run_command(4'($urandom_range(8)), 8'($urandom), SDA_RANDOM);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_word(1'($urandom_range(1)), 4'($urandom_range(15)), 8'($urandom),
                      1'($urandom_range(1)));
          end
        end
        if ($urandom_range(3) == 0) begin
          idle_ticks($urandom_range(1, 3));
        end
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ i2c_bit_level_master.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_if.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_bit_level_master.sv
tb/sv/i2cm_pin_monitor.sv
tb/sv/testbench.sv
